### rtl/core/pixel_replicate_scaler_assert.svh
// assertion macros for the pixel replication scaler
// used by pixel_replicate_scaler.sv, needs clk and rst in scope
`ifndef PIXEL_REPLICATE_SCALER_ASSERT_SVH
`define PIXEL_REPLICATE_SCALER_ASSERT_SVH

// same-cycle implication
`define PRS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/prs_pkg.sv
// shared types and constants of the pixel replication scaler
// no dependencies
package prs_pkg;

  localparam int ScaleW = 12;
  localparam int ColW   = 10;
  localparam int RowW   = 10;
  localparam int ValW   = 8;
  localparam int CoordW = 13;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 12;

  localparam int DefMaxDim    = 1024;
  localparam int DefPixelBits = 8;
  localparam int DefMaxScale  = 8;

  // 1.0 in 8 fraction bits
  localparam logic [ScaleW-1:0] ScaleOne = ScaleW'(256);
  localparam int FracBits = 8;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SCALE_H  = 2'd0,
    CFG_SCALE_V  = 2'd1,
    CFG_CLEAR    = 2'd2,
    CFG_RESERVED = 2'd3
  } cfg_index_t;

endpackage

### rtl/core/pixel_replicate_scaler.sv
// pixel replication upscaler, top level
// depends on prs_pkg and pixel_replicate_scaler_assert.svh
//
//  channel   handshake                 payload
//  input     start / busy              source_col, source_row, source_value
//  config    cfg_valid / cfg_ready     cfg_index, cfg_data
//  result    write_strobe (no stall)   dest_col, dest_row, dest_value, final_write
//
// three register stages (capture, multiply, round) feed a write sequencer
// a block of wx*hy writes holds the sequencer until its last write, one write per cycle
// an item with no writes leaves stage 3 without waiting for the sequencer; the sequencer sets the rate
// the front stages take an item every cycle until the sequencer backs them up
// rst is synchronous and clears all valid bits and the registers to 1.0 / 0
// results cannot be held off: write_strobe marks a transfer every cycle it is high
`include "pixel_replicate_scaler_assert.svh"

module pixel_replicate_scaler #(
  parameter int MAX_DIM    = prs_pkg::DefMaxDim,
  parameter int PIXEL_BITS = prs_pkg::DefPixelBits,
  parameter int MAX_SCALE  = prs_pkg::DefMaxScale
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [prs_pkg::ColW-1:0]     source_col,
  input  logic [prs_pkg::RowW-1:0]     source_row,
  input  logic [prs_pkg::ValW-1:0]     source_value,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [prs_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [prs_pkg::CfgDataW-1:0] cfg_data,
  output logic                         write_strobe,
  output logic [prs_pkg::CoordW-1:0]   dest_col,
  output logic [prs_pkg::CoordW-1:0]   dest_row,
  output logic [prs_pkg::ValW-1:0]     dest_value,
  output logic                         final_write
);
  import prs_pkg::*;

  // block extent never exceeds MAX_SCALE
  localparam int ExtW  = $clog2(MAX_SCALE + 1);
  localparam int ProdW = ScaleW + ColW;
  localparam int SumW  = ProdW + 1;
  localparam int DiffW = SumW - FracBits;
  localparam logic [ScaleW:0] ScaleLim = (ScaleW + 1)'(MAX_SCALE * 256);
  localparam logic [ValW-1:0] PixMask =
    (PIXEL_BITS >= ValW) ? {ValW{1'b1}} : ValW'((1 << PIXEL_BITS) - 1);
  localparam logic [SumW-1:0] RoundHalf = SumW'(1 << (FracBits - 1));

  // configuration registers
  logic [ScaleW-1:0] scale_h;
  logic [ScaleW-1:0] scale_v;
  logic [ValW-1:0]   clear_value;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_h     <= ScaleOne;
      scale_v     <= ScaleOne;
      clear_value <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_SCALE_H:  scale_h     <= cfg_data[ScaleW-1:0];
        CFG_SCALE_V:  scale_v     <= cfg_data[ScaleW-1:0];
        CFG_CLEAR:    clear_value <= cfg_data[ValW-1:0];
        default:      ;
      endcase
    end
  end

  // pipeline advance, back to front
  logic s1_valid, s2_valid, s3_valid;
  logic s3_empty;
  logic e_active, e_last, e_free;
  logic s3_take, adv3, adv2, adv1;
  logic accept;

  assign e_free  = !e_active || e_last;
  // an item with no writes drains without waiting for the sequencer
  assign s3_take = s3_valid && (e_free || s3_empty);
  assign adv3    = !s3_valid || s3_take;
  assign adv2    = !s2_valid || adv3;
  assign adv1    = !s1_valid || adv2;
  assign busy    = !adv1;
  assign accept  = start && !busy;

  // stage 1: capture, clamp scales, decide skip
  logic [ColW-1:0]   s1_col;
  logic [RowW-1:0]   s1_row;
  logic [ValW-1:0]   s1_val;
  logic [ScaleW-1:0] s1_sx, s1_sy;
  logic              s1_skip;

  logic [ValW-1:0]   in_val;
  logic              in_unity, in_clear, in_outside;

  assign in_val     = source_value & PixMask;
  assign in_unity   = (scale_h == ScaleOne) && (scale_v == ScaleOne);
  assign in_clear   = in_val == (clear_value & PixMask);
  assign in_outside = (32'(source_col) >= 32'(MAX_DIM)) || (32'(source_row) >= 32'(MAX_DIM));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv1) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_col  <= source_col;
      s1_row  <= source_row;
      s1_val  <= in_val;
      s1_sx   <= ({1'b0, scale_h} > ScaleLim) ? ScaleLim[ScaleW-1:0] : scale_h;
      s1_sy   <= ({1'b0, scale_v} > ScaleLim) ? ScaleLim[ScaleW-1:0] : scale_v;
      // a 1.0 copy is written whatever the value
      s1_skip <= in_outside || (!in_unity && in_clear);
    end
  end

  // stage 2: scale times coordinate
  logic [ProdW-1:0]  s2_px, s2_py;
  logic [ScaleW-1:0] s2_sx, s2_sy;
  logic [ValW-1:0]   s2_val;
  logic              s2_skip;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_px   <= ProdW'(s1_sx) * ProdW'(s1_col);
      s2_py   <= ProdW'(s1_sy) * ProdW'(s1_row);
      s2_sx   <= s1_sx;
      s2_sy   <= s1_sy;
      s2_val  <= s1_val;
      s2_skip <= s1_skip;
    end
  end

  // stage 3: round half up for origin and far edge, extent is the difference
  logic [SumW-1:0]  sum_x0, sum_x1, sum_y0, sum_y1;
  logic [DiffW-1:0] ext_x, ext_y;

  assign sum_x0 = SumW'(s2_px) + RoundHalf;
  assign sum_x1 = sum_x0 + SumW'(s2_sx);
  assign sum_y0 = SumW'(s2_py) + RoundHalf;
  assign sum_y1 = sum_y0 + SumW'(s2_sy);
  assign ext_x  = sum_x1[SumW-1:FracBits] - sum_x0[SumW-1:FracBits];
  assign ext_y  = sum_y1[SumW-1:FracBits] - sum_y0[SumW-1:FracBits];

  logic [CoordW-1:0] s3_x0, s3_y0;
  logic [ExtW-1:0]   s3_wx, s3_hy;
  logic [ValW-1:0]   s3_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv3) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      s3_x0    <= sum_x0[FracBits +: CoordW];
      s3_y0    <= sum_y0[FracBits +: CoordW];
      s3_wx    <= ExtW'(ext_x);
      s3_hy    <= ExtW'(ext_y);
      s3_val   <= s2_val;
      s3_empty <= s2_skip || (ext_x == '0) || (ext_y == '0);
    end
  end

  // write sequencer: column outer, row inner
  logic [CoordW-1:0] e_col, e_row, e_row_base;
  logic [ExtW-1:0]   e_col_left, e_row_left, e_hy_m1;
  logic [ValW-1:0]   e_val;
  logic              e_load;

  assign e_last = e_active && (e_col_left == '0) && (e_row_left == '0);
  assign e_load = s3_take && !s3_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_active <= 1'b0;
    end else if (e_load) begin
      e_active <= 1'b1;
    end else if (e_last) begin
      e_active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (e_load) begin
      e_col      <= s3_x0;
      e_row      <= s3_y0;
      e_row_base <= s3_y0;
      e_col_left <= s3_wx - ExtW'(1);
      e_row_left <= s3_hy - ExtW'(1);
      e_hy_m1    <= s3_hy - ExtW'(1);
      e_val      <= s3_val;
    end else if (e_active) begin
      priority if (e_row_left != '0) begin
        e_row      <= e_row + CoordW'(1);
        e_row_left <= e_row_left - ExtW'(1);
      end else if (e_col_left != '0) begin
        // next column, rows start again
        e_col      <= e_col + CoordW'(1);
        e_col_left <= e_col_left - ExtW'(1);
        e_row      <= e_row_base;
        e_row_left <= e_hy_m1;
      end else begin
      end
    end
  end

  assign write_strobe = e_active;
  assign dest_col     = e_col;
  assign dest_row     = e_row;
  assign dest_value   = e_val;
  assign final_write  = e_last;

  // inside a block the writes come without gaps
  `PRS_ASSERT_NEXT(a_no_gap, write_strobe && !final_write, write_strobe, "gap inside a block")
  // column only stays or steps by one inside a block
  `PRS_ASSERT_NEXT(a_col_step, write_strobe && !final_write,
    (dest_col == $past(dest_col)) || (dest_col == $past(dest_col) + CoordW'(1)),
    "column jump inside a block")
  // rows step by one while rows remain
  `PRS_ASSERT_NEXT(a_row_step, e_active && !e_load && (e_row_left != '0),
    dest_row == $past(dest_row) + CoordW'(1), "row did not step")
  // the sequencer only takes a block when it is free
  `PRS_ASSERT_NOW(a_load_free, e_load, e_free, "block loaded over a running one")

endmodule

### test/tb_pixel_replicate_scaler.sv
// testbench for the pixel replication scaler: directed and random source pixels under
// many scale and clear-value settings, each write checked against an in-bench predictor
// depends on prs_pkg and the pixel_replicate_scaler rtl
`timescale 1ns / 100ps

module tb_pixel_replicate_scaler;
  import prs_pkg::*;

  // generous bound on the whole run, in clock cycles
  localparam int CycleLimit = 400000;
  // settle time after the last expected write, covers the three front stages
  localparam int SettleCycles = 16;

  // one destination write as the block should produce it
  typedef struct {
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic [ValW-1:0]   value;
    logic              final_flag;
  } dest_write_t;

  // keeps a copy of the registers, expands each accepted pixel into its writes
  // and checks the block's writes in order against them
  class replica_scoreboard;
    logic [ScaleW-1:0] scale_x;
    logic [ScaleW-1:0] scale_y;
    logic [ValW-1:0]   clear_value;
    dest_write_t       pending_writes[$];
    int                pixels_noted;
    int                pixels_dropped;
    int                writes_checked;
    int                errors;

    function new();
      scale_x        = ScaleOne;
      scale_y        = ScaleOne;
      clear_value    = '0;
      pixels_noted   = 0;
      pixels_dropped = 0;
      writes_checked = 0;
      errors         = 0;
    endfunction

    function void set_register(cfg_index_t idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_SCALE_H: scale_x = data[ScaleW-1:0];
        CFG_SCALE_V: scale_y = data[ScaleW-1:0];
        CFG_CLEAR:   clear_value = data[ValW-1:0];
        default: ;
      endcase
    endfunction

    // round half up of scale * coord, 8 fraction bits
    function int unsigned block_edge(int unsigned scale, int unsigned coord);
      return (scale * coord + (1 << (FracBits - 1))) >> FracBits;
    endfunction

    function void note_pixel(logic [ColW-1:0] col, logic [RowW-1:0] row,
                             logic [ValW-1:0] value);
      int unsigned limit;
      int unsigned sx;
      int unsigned sy;
      int unsigned x0;
      int unsigned y0;
      int unsigned wx;
      int unsigned hy;
      dest_write_t w;
      pixels_noted++;
      w.value = value;
      // exactly unit scale: plain copy, the clear value does not apply
      if (scale_x == ScaleOne && scale_y == ScaleOne) begin
        w.col        = CoordW'(col);
        w.row        = CoordW'(row);
        w.final_flag = 1'b1;
        pending_writes.push_back(w);
        return;
      end
      if (value == clear_value) begin
        pixels_dropped++;
        return;
      end
      limit = DefMaxScale << FracBits;
      sx = (scale_x > limit) ? limit : scale_x;
      sy = (scale_y > limit) ? limit : scale_y;
      x0 = block_edge(sx, col);
      y0 = block_edge(sy, row);
      wx = block_edge(sx, col + 1) - x0;
      hy = block_edge(sy, row + 1) - y0;
      // column outer, row inner
      for (int unsigned i = 0; i < wx; i++) begin
        for (int unsigned j = 0; j < hy; j++) begin
          w.col        = CoordW'(x0 + i);
          w.row        = CoordW'(y0 + j);
          w.final_flag = (i + 1 == wx) && (j + 1 == hy);
          pending_writes.push_back(w);
        end
      end
    endfunction

    function void check_write(logic [CoordW-1:0] col, logic [CoordW-1:0] row,
                              logic [ValW-1:0] value, logic final_flag);
      dest_write_t w;
      if (pending_writes.size() == 0) begin
        $error("unexpected write: dest_col %0d dest_row %0d dest_value %0d", col, row, value);
        errors++;
        return;
      end
      w = pending_writes.pop_front();
      writes_checked++;
      if (col !== w.col) begin
        $error("dest_col: expected %0d, got %0d", w.col, col);
        errors++;
      end
      if (row !== w.row) begin
        $error("dest_row: expected %0d, got %0d", w.row, row);
        errors++;
      end
      if (value !== w.value) begin
        $error("dest_value: expected %0d, got %0d", w.value, value);
        errors++;
      end
      if (final_flag !== w.final_flag) begin
        $error("final_write: expected %0d, got %0d", w.final_flag, final_flag);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [ColW-1:0]     source_col;
  logic [RowW-1:0]     source_row;
  logic [ValW-1:0]     source_value;
  logic                cfg_valid;
  logic                cfg_ready;
  cfg_index_t          cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic                write_strobe;
  logic [CoordW-1:0]   dest_col;
  logic [CoordW-1:0]   dest_row;
  logic [ValW-1:0]     dest_value;
  logic                final_write;

  replica_scoreboard sb = new();
  int                cycle_count = 0;
  int                settings_used = 0;

  pixel_replicate_scaler dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .source_col   (source_col),
    .source_row   (source_row),
    .source_value (source_value),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .write_strobe (write_strobe),
    .dest_col     (dest_col),
    .dest_row     (dest_row),
    .dest_value   (dest_value),
    .final_write  (final_write)
  );

  // 20 ns clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // watchdog: a hung handshake or a lost write ends the run here
  initial begin
    wait (cycle_count >= CycleLimit);
    $display("timeout after %0d cycles, %0d writes still expected",
             cycle_count, sb.pending_writes.size());
    $display("Verification failed");
    $finish;
  end

  // monitor: values read at the rising edge are the ones of the cycle that edge ends
  // note the pixel transfer first, so the queue order stays source order
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_pixel(source_col, source_row, source_value);
      if (write_strobe) sb.check_write(dest_col, dest_row, dest_value, final_write);
    end
  end

  // one register transfer; valid drops at the next falling edge
  task automatic write_reg(cfg_index_t idx, logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // offer one source pixel, with random idle cycles ahead of it
  // start stays high after the transfer so back-to-back pixels need no gap
  task automatic send_pixel(logic [ColW-1:0] col, logic [RowW-1:0] row,
                            logic [ValW-1:0] value, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start        = 1'b1;
    source_col   = col;
    source_row   = row;
    source_value = value;
    do @(posedge clk); while (busy);
  endtask

  // drop start, let every expected write arrive, then let pixels with no writes
  // clear the front stages before anything touches the registers
  task automatic wait_idle();
    @(negedge clk);
    start = 1'b0;
    while (sb.pending_writes.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic configure(int unsigned h, int unsigned v, int unsigned clr);
    wait_idle();
    write_reg(CFG_SCALE_H, CfgDataW'(h));
    write_reg(CFG_SCALE_V, CfgDataW'(v));
    write_reg(CFG_CLEAR, CfgDataW'(clr));
    settings_used++;
  endtask

  // random coordinate, now and then pinned to an image edge
  function automatic logic [ColW-1:0] pick_coord();
    if ($urandom_range(99) < 10) return $urandom_range(1) ? '1 : '0;
    return ColW'($urandom_range(DefMaxDim - 1));
  endfunction

  // random pixels under one register setting; some carry the clear value
  task automatic run_phase(int unsigned h, int unsigned v, int unsigned clr,
                           int count, int idle_pct);
    logic [ValW-1:0] value;
    configure(h, v, clr);
    for (int i = 0; i < count; i++) begin
      value = ($urandom_range(99) < 15) ? ValW'(clr) : ValW'($urandom_range(255));
      send_pixel(pick_coord(), pick_coord(), value, idle_pct);
    end
  endtask

  int idle_mix[4] = '{0, 55, 0, 23};

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    source_col   = '0;
    source_row   = '0;
    source_value = '0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_SCALE_H;
    cfg_data     = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset setting is unit scale: copies, even of the clear value
    send_pixel('0, '0, 8'h00, 0);
    send_pixel('1, '1, 8'hFF, 0);
    send_pixel('0, '1, 8'h55, 0);
    send_pixel('1, '0, 8'hAA, 0);

    // largest block, 8 by 8, out to the far corner of the destination
    configure(2048, 2048, 8'h5A);
    send_pixel('1, '1, 8'hA5, 0);
    send_pixel('0, '0, 8'h5A, 0);  // clear value, dropped
    send_pixel('0, '0, 8'h00, 0);
    send_pixel(10'd512, 10'd3, 8'hFF, 0);

    // fractional scales, some blocks one wide and some empty
    configure(384, 128, 8'h00);
    write_reg(CFG_RESERVED, '1);  // unused index, no effect
    send_pixel(10'd0, 10'd0, 8'h01, 0);
    send_pixel(10'd1, 10'd1, 8'h80, 0);
    send_pixel(10'd2, 10'd3, 8'h7F, 0);
    send_pixel('1, '1, 8'h00, 0);  // clear value, dropped

    // zero horizontal scale: every block is empty
    configure(0, 256, 8'hFF);
    send_pixel(10'd5, 10'd5, 8'h07, 0);
    send_pixel('1, '1, 8'hFE, 0);

    // random part, cycling through the sender idle patterns
    run_phase(256, 256, 8'h00, 50, idle_mix[0]);
    run_phase(512, 512, 8'hFF, 60, idle_mix[1]);
    run_phase(384, 640, 8'h80, 60, idle_mix[2]);
    run_phase(2048, 2048, $urandom_range(255), 30, idle_mix[3]);
    run_phase(4095, 3000, 8'h01, 30, idle_mix[0]);  // both clamp to the maximum
    run_phase(256, 257, 8'h3C, 50, idle_mix[1]);    // near unit, clear value applies
    run_phase(300, 256, 8'hC3, 50, idle_mix[2]);
    run_phase(100, 1, 8'h10, 30, idle_mix[3]);      // tiny scales, mostly empty blocks
    run_phase(768, 1024, 8'h7E, 30, idle_mix[0]);
    run_phase($urandom_range(4095), $urandom_range(4095), $urandom_range(255), 30,
              idle_mix[1]);

    wait_idle();

    $display("%0d source pixels over %0d register settings, %0d dropped as clear",
             sb.pixels_noted, settings_used + 1, sb.pixels_dropped);
    $display("%0d destination writes checked, %0d mismatches",
             sb.writes_checked, sb.errors);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
